>>> src/dsl_token_lexer_assert.svh
// Assertion macros for the token lexer checker.
// Expects clk and rst_n in the scope of use.
`ifndef DSL_TOKEN_LEXER_ASSERT_SVH
`define DSL_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication
`define DTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/dtl_pkg.sv
// Shared types and constants for the token lexer.
// No dependencies.
package dtl_pkg;

    localparam int POSITION_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH        = 16;
    localparam int KW_SPAN            = 10;
    localparam int KW_IDX_W           = $clog2(KW_SPAN);
    localparam int QUEUE_DEPTH        = 4;
    localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [FIELD_WIDTH-1:0] LEN_MAX = {FIELD_WIDTH{1'b1}};

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    typedef enum logic [4:0] {
        KIND_COMMA      = 5'd0,
        KIND_COLON      = 5'd1,
        KIND_LBRACE     = 5'd2,
        KIND_RBRACE     = 5'd3,
        KIND_AT         = 5'd4,
        KIND_IDENT      = 5'd5,
        KIND_ENUM       = 5'd6,
        KIND_CLASS      = 5'd7,
        KIND_FUNCTION   = 5'd8,
        KIND_METHOD     = 5'd9,
        KIND_PROMPT     = 5'd10,
        KIND_INPUT      = 5'd11,
        KIND_OUTPUT     = 5'd12,
        KIND_DEPENDS    = 5'd13,
        KIND_TESTGROUP  = 5'd14,
        KIND_CASE       = 5'd15,
        KIND_VARIANT    = 5'd16,
        KIND_LANG       = 5'd17,
        KIND_CLIENT     = 5'd18,
        KIND_PROVIDER   = 5'd19,
        KIND_RENAME     = 5'd20,
        KIND_DESCRIBE   = 5'd21,
        KIND_SKIP       = 5'd22,
        KIND_STRINGIFY  = 5'd23,
        KIND_RETRY      = 5'd24,
        KIND_FALLBACK   = 5'd25,
        KIND_EOF        = 5'd26
    } kind_t;

    typedef enum logic [1:0] {
        CLS_PUNCT,
        CLS_SEP,
        CLS_LF,
        CLS_WORD
    } byte_class_t;

    typedef logic [KW_SPAN-1:0][7:0] prefix_t;

    typedef struct packed {
        kind_t                  kind;
        logic [FIELD_WIDTH-1:0] line_no;
        logic [FIELD_WIDTH-1:0] col_no;
        logic [FIELD_WIDTH-1:0] len;
        logic                   last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } queue_wr_t;

endpackage

>>> src/dsl_token_lexer.sv
// Token lexer top level: byte front end feeding a token queue.
// Depends on dtl_pkg, dtl_front and dtl_queue.
//
// Byte channel: byte_valid/byte_stall with action and char_code. A beat
// carries one source byte, or the end-of-input mark when action is set.
// Token channel: token_valid/token_stall with kind, line, column, length
// and last_of_run, which marks the final token that a byte beat caused.
// A byte beat yields zero, one or two tokens; they are written into the token
// queue as the beat is taken and leave it one per beat while token_stall is low.
// One byte is taken every cycle while the four-entry token queue holds two
// or fewer tokens; byte_stall rises once three are held. Sustained token
// output is one per cycle without token_stall, so a byte making two tokens costs two output beats.
// Keyword matching compares the buffered word head against a fixed table in
// the cycle of the closing byte.
// When token_stall is high the head token holds and the queue fills, then
// byte_stall rises. Reset empties the queue and returns line and column to 1;
// no clearing pass is needed. End of input also returns the front end to its
// reset state, so a new stream may follow at once.
module dsl_token_lexer #(
    parameter int POSITION_WIDTH = dtl_pkg::POSITION_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               byte_valid,
    output logic                               byte_stall,
    input  logic                               action,
    input  logic [7:0]                         char_code,
    output logic                               token_valid,
    input  logic                               token_stall,
    output logic [4:0]                         token_kind,
    output logic [dtl_pkg::FIELD_WIDTH-1:0]    line_number,
    output logic [dtl_pkg::FIELD_WIDTH-1:0]    column_number,
    output logic [dtl_pkg::FIELD_WIDTH-1:0]    token_length,
    output logic                               last_of_run
);

    dtl_pkg::queue_wr_t wr;
    logic               room;

    dtl_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .action     (action),
        .char_code  (char_code),
        .room       (room),
        .wr         (wr)
    );

    dtl_queue u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr            (wr),
        .room          (room),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .line_number   (line_number),
        .column_number (column_number),
        .token_length  (token_length),
        .last_of_run   (last_of_run)
    );

endmodule

>>> src/dtl_classify.sv
// Keyword classifier for a word that follows an at-sign.
// Depends on dtl_pkg.
module dtl_classify (
    input  dtl_pkg::prefix_t                 prefix,
    input  logic [dtl_pkg::FIELD_WIDTH-1:0]  word_length,
    input  logic [7:0]                       final_byte,
    output dtl_pkg::kind_t                   kind
);

    localparam int WB = dtl_pkg::KW_SPAN * 8;

    logic [WB-1:0] w;
    logic          rb;

    // first byte of the word in the top byte, to line up with string literals
    always_comb
    begin
        for (int i = 0; i < dtl_pkg::KW_SPAN; i++)
        begin
            w[(dtl_pkg::KW_SPAN-1-i)*8 +: 8] = prefix[i];
        end
    end

    assign rb = (final_byte == dtl_pkg::CH_RBRACK);

    always_comb
    begin
        priority if (word_length == 16'd4 && w[WB-1 -: 32] == "enum")
            kind = dtl_pkg::KIND_ENUM;
        else if (word_length == 16'd5 && w[WB-1 -: 40] == "class")
            kind = dtl_pkg::KIND_CLASS;
        else if (word_length == 16'd8 && w[WB-1 -: 64] == "function")
            kind = dtl_pkg::KIND_FUNCTION;
        else if (word_length == 16'd6 && w[WB-1 -: 48] == "method")
            kind = dtl_pkg::KIND_METHOD;
        else if (word_length == 16'd6 && w[WB-1 -: 48] == "prompt")
            kind = dtl_pkg::KIND_PROMPT;
        else if (word_length == 16'd5 && w[WB-1 -: 40] == "input")
            kind = dtl_pkg::KIND_INPUT;
        else if (word_length == 16'd6 && w[WB-1 -: 48] == "output")
            kind = dtl_pkg::KIND_OUTPUT;
        else if (word_length == 16'd10 && w[WB-1 -: 80] == {"depends", "_on"})
            kind = dtl_pkg::KIND_DEPENDS;
        else if (word_length == 16'd10 && w[WB-1 -: 80] == {"test", "_group"})
            kind = dtl_pkg::KIND_TESTGROUP;
        else if (word_length == 16'd4 && w[WB-1 -: 32] == "case")
            kind = dtl_pkg::KIND_CASE;
        else if (word_length == 16'd8 && w[WB-1 -: 64] == "provider")
            kind = dtl_pkg::KIND_PROVIDER;
        else if (word_length == 16'd6 && w[WB-1 -: 48] == "rename")
            kind = dtl_pkg::KIND_RENAME;
        else if (word_length == 16'd8 && w[WB-1 -: 64] == "describe")
            kind = dtl_pkg::KIND_DESCRIBE;
        else if (word_length == 16'd4 && w[WB-1 -: 32] == "skip")
            kind = dtl_pkg::KIND_SKIP;
        else if (word_length == 16'd9 && w[WB-1 -: 72] == "stringify")
            kind = dtl_pkg::KIND_STRINGIFY;
        else if (word_length == 16'd5 && w[WB-1 -: 40] == "retry")
            kind = dtl_pkg::KIND_RETRY;
        else if (word_length == 16'd8 && w[WB-1 -: 64] == "fallback")
            kind = dtl_pkg::KIND_FALLBACK;
        else if (rb && word_length > 16'd5 && w[WB-1 -: 40] == "lang[")
            kind = dtl_pkg::KIND_LANG;
        else if (rb && word_length > 16'd8 && w[WB-1 -: 64] == "variant[")
            kind = dtl_pkg::KIND_VARIANT;
        else if (rb && word_length > 16'd7 && w[WB-1 -: 56] == "client[")
            kind = dtl_pkg::KIND_CLIENT;
        else if (rb && word_length > 16'd9 && w[WB-1 -: 72] == "fallback[")
            kind = dtl_pkg::KIND_FALLBACK;
        else
            kind = dtl_pkg::KIND_IDENT;
    end

endmodule

>>> src/dtl_front.sv
// Front end: accepts bytes, tracks word and position state, forms tokens.
// Depends on dtl_pkg and dtl_classify.
module dtl_front #(
    parameter int POSITION_WIDTH = dtl_pkg::POSITION_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  logic                 action,
    input  logic [7:0]           char_code,
    input  logic                 room,
    output dtl_pkg::queue_wr_t   wr
);

    localparam int FW    = dtl_pkg::FIELD_WIDTH;
    localparam int PW    = POSITION_WIDTH;
    localparam int SUM_W = ((PW > FW) ? PW : FW) + 2;
    localparam logic [SUM_W-1:0] POS_MAX = {{(SUM_W-PW){1'b0}}, {PW{1'b1}}};

    dtl_pkg::prefix_t  prefix_reg;
    logic [FW-1:0]     len_reg, len_next;
    logic [7:0]        final_reg, final_next;
    logic              at_reg, at_next;
    logic [PW-1:0]     line_reg, line_next;
    logic [PW-1:0]     col_reg, col_next;
    logic              open_reg, open_next;

    logic                 accept;
    logic                 has_word;
    logic                 prefix_we;
    dtl_pkg::byte_class_t cls;
    dtl_pkg::kind_t       cls_kind;
    dtl_pkg::kind_t       word_kind;
    dtl_pkg::kind_t       punct_kind;
    logic [PW-1:0]        col_flush, col_step, line_inc;
    dtl_pkg::token_t      tok_word, tok_punct, tok_eof;

    function automatic logic [PW-1:0] sat_pos(input logic [SUM_W-1:0] v);
        return (v > POS_MAX) ? POS_MAX[PW-1:0] : v[PW-1:0];
    endfunction

    function automatic logic [FW-1:0] pos_field(input logic [PW-1:0] p);
        logic [SUM_W-1:0] e;
        e = SUM_W'(p);
        return e[FW-1:0];
    endfunction

    dtl_classify u_cls (
        .prefix      (prefix_reg),
        .word_length (len_reg),
        .final_byte  (final_reg),
        .kind        (cls_kind)
    );

    assign byte_stall = ~room;
    assign accept     = byte_valid & room;
    assign has_word   = (len_reg != '0);
    assign word_kind  = at_reg ? cls_kind : dtl_pkg::KIND_IDENT;

    always_comb
    begin
        unique case (char_code)
            dtl_pkg::CH_COMMA, dtl_pkg::CH_COLON, dtl_pkg::CH_LBRACE,
            dtl_pkg::CH_RBRACE, dtl_pkg::CH_AT:
                cls = dtl_pkg::CLS_PUNCT;
            dtl_pkg::CH_SPACE, dtl_pkg::CH_TAB, dtl_pkg::CH_CR:
                cls = dtl_pkg::CLS_SEP;
            dtl_pkg::CH_LF:
                cls = dtl_pkg::CLS_LF;
            default:
                cls = dtl_pkg::CLS_WORD;
        endcase
    end

    always_comb
    begin
        unique case (char_code)
            dtl_pkg::CH_COMMA:  punct_kind = dtl_pkg::KIND_COMMA;
            dtl_pkg::CH_COLON:  punct_kind = dtl_pkg::KIND_COLON;
            dtl_pkg::CH_LBRACE: punct_kind = dtl_pkg::KIND_LBRACE;
            dtl_pkg::CH_RBRACE: punct_kind = dtl_pkg::KIND_RBRACE;
            default:            punct_kind = dtl_pkg::KIND_AT;
        endcase
    end

    // flushing a word then stepping one column saturates the same as one sum
    assign col_flush = sat_pos(SUM_W'(col_reg) + SUM_W'(len_reg));
    assign col_step  = sat_pos(SUM_W'(col_reg) + SUM_W'(len_reg) + SUM_W'(1));
    assign line_inc  = sat_pos(SUM_W'(line_reg) + SUM_W'(1));

    always_comb
    begin
        tok_word = '{kind: word_kind, line_no: pos_field(line_reg),
                     col_no: pos_field(col_reg), len: len_reg, last: 1'b0};
        tok_punct = '{kind: punct_kind, line_no: pos_field(line_reg),
                      col_no: pos_field(col_flush), len: FW'(1), last: 1'b1};
        tok_eof = '{kind: dtl_pkg::KIND_EOF,
                    line_no: pos_field(open_reg ? line_inc : line_reg),
                    col_no: FW'(1), len: '0, last: 1'b1};
    end

    assign prefix_we = accept && action == dtl_pkg::ACT_BYTE &&
                       cls == dtl_pkg::CLS_WORD && len_reg < FW'(dtl_pkg::KW_SPAN);

    always_comb
    begin
        len_next   = len_reg;
        final_next = final_reg;
        at_next    = at_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        open_next  = open_reg;
        wr         = '0;
        if (accept)
        begin
            if (action == dtl_pkg::ACT_END)
            begin
                if (open_reg && has_word)
                begin
                    wr.count  = 2'd2;
                    wr.first  = tok_word;
                    wr.second = tok_eof;
                end
                else
                begin
                    wr.count = 2'd1;
                    wr.first = tok_eof;
                end
                len_next   = '0;
                final_next = '0;
                at_next    = 1'b0;
                line_next  = PW'(1);
                col_next   = PW'(1);
                open_next  = 1'b0;
            end
            else
            begin
                unique case (cls)
                    dtl_pkg::CLS_PUNCT:
                    begin
                        if (has_word)
                        begin
                            wr.count  = 2'd2;
                            wr.first  = tok_word;
                            wr.second = tok_punct;
                        end
                        else
                        begin
                            wr.count = 2'd1;
                            wr.first = tok_punct;
                        end
                        len_next  = '0;
                        at_next   = (char_code == dtl_pkg::CH_AT);
                        col_next  = col_step;
                        open_next = 1'b1;
                    end
                    dtl_pkg::CLS_SEP:
                    begin
                        if (has_word)
                        begin
                            wr.count      = 2'd1;
                            wr.first      = tok_word;
                            wr.first.last = 1'b1;
                        end
                        len_next  = '0;
                        at_next   = 1'b0;
                        col_next  = col_step;
                        open_next = 1'b1;
                    end
                    dtl_pkg::CLS_LF:
                    begin
                        if (has_word)
                        begin
                            wr.count      = 2'd1;
                            wr.first      = tok_word;
                            wr.first.last = 1'b1;
                        end
                        len_next  = '0;
                        at_next   = 1'b0;
                        line_next = line_inc;
                        col_next  = PW'(1);
                        open_next = 1'b0;
                    end
                    dtl_pkg::CLS_WORD:
                    begin
                        if (len_reg != dtl_pkg::LEN_MAX)
                            len_next = len_reg + FW'(1);
                        final_next = char_code;
                        open_next  = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prefix_we)
            prefix_reg[len_reg[dtl_pkg::KW_IDX_W-1:0]] <= char_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            final_reg <= '0;
            at_reg    <= 1'b0;
            line_reg  <= PW'(1);
            col_reg   <= PW'(1);
            open_reg  <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            final_reg <= final_next;
            at_reg    <= at_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            open_reg  <= open_next;
        end
    end

endmodule

>>> src/dtl_queue.sv
// Back end: token queue taking up to two tokens a cycle, draining one a beat.
// Depends on dtl_pkg.
module dtl_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  dtl_pkg::queue_wr_t                 wr,
    output logic                               room,
    output logic                               token_valid,
    input  logic                               token_stall,
    output logic [4:0]                         token_kind,
    output logic [dtl_pkg::FIELD_WIDTH-1:0]    line_number,
    output logic [dtl_pkg::FIELD_WIDTH-1:0]    column_number,
    output logic [dtl_pkg::FIELD_WIDTH-1:0]    token_length,
    output logic                               last_of_run
);

    localparam int PTR_W = dtl_pkg::QUEUE_PTR_W;
    localparam int CNT_W = dtl_pkg::QUEUE_CNT_W;

    dtl_pkg::token_t mem [dtl_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    dtl_pkg::token_t  head;

    assign room        = (count_reg <= CNT_W'(dtl_pkg::QUEUE_DEPTH - 2));
    assign token_valid = (count_reg != '0);
    assign pop         = token_valid & ~token_stall;
    assign head        = mem[rd_ptr_reg];

    assign token_kind    = head.kind;
    assign line_number   = head.line_no;
    assign column_number = head.col_no;
    assign token_length  = head.len;
    assign last_of_run   = head.last;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(wr.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(wr.count) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
            mem[wr_ptr_reg] <= wr.first;
        if (wr.count == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= wr.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/dtl_checker.sv
// Port-level checks on the token channel of the lexer, bound to the top.
// Depends on dtl_pkg and dsl_token_lexer_assert.svh.
`include "dsl_token_lexer_assert.svh"

module dtl_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               token_valid,
    input logic                               token_stall,
    input logic [4:0]                         token_kind,
    input logic [dtl_pkg::FIELD_WIDTH-1:0]    column_number,
    input logic [dtl_pkg::FIELD_WIDTH-1:0]    token_length,
    input logic                               last_of_run
);

    `DTL_ASSERT_NOW(a_eof_last, token_valid && token_kind == dtl_pkg::KIND_EOF, last_of_run, "eof not last of run")
    `DTL_ASSERT_NOW(a_eof_shape, token_valid && token_kind == dtl_pkg::KIND_EOF, token_length == '0 && column_number == 16'd1, "eof length or column wrong")
    `DTL_ASSERT_NOW(a_punct_len, token_valid && token_kind <= dtl_pkg::KIND_AT, token_length == 16'd1, "punctuation length not one")
    `DTL_ASSERT_NEXT(a_hold, token_valid && token_stall, token_valid && $stable(token_kind) && $stable(token_length) && $stable(last_of_run), "stalled token changed")

endmodule

bind dsl_token_lexer dtl_checker u_dtl_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for dsl_token_lexer: streams source bytes under random
// idling and back-pressure and checks every token against an in-bench lexer model.
// Depends on dtl_pkg and the dsl_token_lexer RTL only.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD = 8;
    localparam int          HEAD_DEPTH = 16;
    localparam logic [15:0] POS_MAX    = 16'hFFFF;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_stall;
    logic        action;
    logic [7:0]  char_code;
    logic        token_valid;
    logic        token_stall;
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic [15:0] token_length;
    logic        last_of_run;

    dsl_token_lexer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .action        (action),
        .char_code     (char_code),
        .token_valid   (token_valid),
        .token_stall   (token_stall),
        .token_kind    (token_kind),
        .line_number   (line_number),
        .column_number (column_number),
        .token_length  (token_length),
        .last_of_run   (last_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    string exact_words [17] = '{"enum", "class", "function", "method", "prompt", "input",
                                "output", {"depends", "_on"}, {"test", "_group"}, "case",
                                "provider", "rename", "describe", "skip", "stringify",
                                "retry", "fallback"};
    dtl_pkg::kind_t exact_kinds [17] = '{dtl_pkg::KIND_ENUM, dtl_pkg::KIND_CLASS,
                                         dtl_pkg::KIND_FUNCTION, dtl_pkg::KIND_METHOD,
                                         dtl_pkg::KIND_PROMPT, dtl_pkg::KIND_INPUT,
                                         dtl_pkg::KIND_OUTPUT, dtl_pkg::KIND_DEPENDS,
                                         dtl_pkg::KIND_TESTGROUP, dtl_pkg::KIND_CASE,
                                         dtl_pkg::KIND_PROVIDER, dtl_pkg::KIND_RENAME,
                                         dtl_pkg::KIND_DESCRIBE, dtl_pkg::KIND_SKIP,
                                         dtl_pkg::KIND_STRINGIFY, dtl_pkg::KIND_RETRY,
                                         dtl_pkg::KIND_FALLBACK};
    string bracket_heads [4] = '{"lang[", "variant[", "client[", "fallback["};
    dtl_pkg::kind_t bracket_kinds [4] = '{dtl_pkg::KIND_LANG, dtl_pkg::KIND_VARIANT,
                                          dtl_pkg::KIND_CLIENT, dtl_pkg::KIND_FALLBACK};
    logic [7:0] punct_bytes [5] = '{dtl_pkg::CH_COMMA, dtl_pkg::CH_COLON,
                                    dtl_pkg::CH_LBRACE, dtl_pkg::CH_RBRACE,
                                    dtl_pkg::CH_AT};

    // lexer model state
    logic [7:0]  word_head [HEAD_DEPTH];
    logic [15:0] word_len;
    logic [7:0]  word_tail;
    logic        after_at;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic        line_has_bytes;

    dtl_pkg::token_t tokens_due [$];
    int     mismatches = 0;
    int     beats_sent = 0;
    int     src_idle_max = 13;
    int     sink_idle_max = 13;
    int     sink_hold = 0;

    function automatic int draw_wait(int most);
        if (most == 0 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, most);
    endfunction

    function automatic dtl_pkg::byte_class_t class_of(logic [7:0] c);
        case (c)
            dtl_pkg::CH_COMMA, dtl_pkg::CH_COLON, dtl_pkg::CH_LBRACE,
            dtl_pkg::CH_RBRACE, dtl_pkg::CH_AT:
                return dtl_pkg::CLS_PUNCT;
            dtl_pkg::CH_SPACE, dtl_pkg::CH_TAB, dtl_pkg::CH_CR:
                return dtl_pkg::CLS_SEP;
            dtl_pkg::CH_LF:
                return dtl_pkg::CLS_LF;
            default:
                return dtl_pkg::CLS_WORD;
        endcase
    endfunction

    function automatic logic [15:0] pos_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? POS_MAX : s[15:0];
    endfunction

    function automatic bit head_matches(string w);
        for (int i = 0; i < w.len(); i++)
            if (word_head[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic dtl_pkg::kind_t keyword_kind();
        for (int i = 0; i < 17; i++)
            if (word_len == exact_words[i].len() && head_matches(exact_words[i]))
                return exact_kinds[i];
        for (int i = 0; i < 4; i++)
            if (word_len > bracket_heads[i].len() && word_tail == dtl_pkg::CH_RBRACK &&
                head_matches(bracket_heads[i]))
                return bracket_kinds[i];
        return dtl_pkg::KIND_IDENT;
    endfunction

    function automatic void push_token(dtl_pkg::kind_t k, logic [15:0] at_line,
                                       logic [15:0] at_col, logic [15:0] span);
        dtl_pkg::token_t t;
        t.kind    = k;
        t.line_no = at_line;
        t.col_no  = at_col;
        t.len     = span;
        t.last    = 1'b0;
        tokens_due.insert(tokens_due.size(), t);
    endfunction

    function automatic void flush_word();
        dtl_pkg::kind_t k;
        if (word_len != 0)
        begin
            if (after_at)
                k = keyword_kind();
            else
                k = dtl_pkg::KIND_IDENT;
            push_token(k, cur_line, cur_col, word_len);
            cur_col  = pos_add(cur_col, word_len);
            word_len = '0;
        end
        after_at = 1'b0;
    endfunction

    function automatic void lex_reset();
        foreach (word_head[i])
            word_head[i] = '0;
        word_len       = '0;
        word_tail      = '0;
        after_at       = 1'b0;
        cur_line       = 16'd1;
        cur_col        = 16'd1;
        line_has_bytes = 1'b0;
    endfunction

    function automatic void lex_beat(logic act, logic [7:0] ch);
        int              base;
        dtl_pkg::token_t t;
        dtl_pkg::kind_t  k;
        base = tokens_due.size();
        if (act == dtl_pkg::ACT_END)
        begin
            if (line_has_bytes)
            begin
                flush_word();
                cur_line = pos_add(cur_line, 16'd1);
            end
            push_token(dtl_pkg::KIND_EOF, cur_line, 16'd1, 16'd0);
            lex_reset();
        end
        else
        begin
            line_has_bytes = (ch != dtl_pkg::CH_LF);
            case (class_of(ch))
                dtl_pkg::CLS_PUNCT:
                begin
                    flush_word();
                    case (ch)
                        dtl_pkg::CH_COMMA:  k = dtl_pkg::KIND_COMMA;
                        dtl_pkg::CH_COLON:  k = dtl_pkg::KIND_COLON;
                        dtl_pkg::CH_LBRACE: k = dtl_pkg::KIND_LBRACE;
                        dtl_pkg::CH_RBRACE: k = dtl_pkg::KIND_RBRACE;
                        default:            k = dtl_pkg::KIND_AT;
                    endcase
                    push_token(k, cur_line, cur_col, 16'd1);
                    if (ch == dtl_pkg::CH_AT)
                        after_at = 1'b1;
                    cur_col = pos_add(cur_col, 16'd1);
                end
                dtl_pkg::CLS_SEP:
                begin
                    flush_word();
                    cur_col = pos_add(cur_col, 16'd1);
                end
                dtl_pkg::CLS_LF:
                begin
                    flush_word();
                    cur_line = pos_add(cur_line, 16'd1);
                    cur_col  = 16'd1;
                end
                default:
                begin
                    if (word_len < HEAD_DEPTH)
                        word_head[word_len] = ch;
                    if (word_len != dtl_pkg::LEN_MAX)
                        word_len = word_len + 16'd1;
                    word_tail = ch;
                end
            endcase
        end
        if (tokens_due.size() > base)
        begin
            t      = tokens_due[tokens_due.size() - 1];
            t.last = 1'b1;
            tokens_due[tokens_due.size() - 1] = t;
        end
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        if ($urandom_range(0, 1) == 1)
            return 8'h61 + 8'($urandom_range(0, 25));
        do
            c = 8'($urandom_range(0, 255));
        while (class_of(c) != dtl_pkg::CLS_WORD);
        return c;
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(0, 2))
            0:       return dtl_pkg::CH_SPACE;
            1:       return dtl_pkg::CH_TAB;
            default: return dtl_pkg::CH_CR;
        endcase
    endfunction

    // one beat on the byte channel; the gap before the next beat is drawn here
    task automatic send_beat(input logic act, input logic [7:0] ch);
        int gap;
        byte_valid <= 1'b1;
        action     <= act;
        char_code  <= ch;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        lex_beat(act, ch);
        beats_sent++;
        gap = draw_wait(src_idle_max);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(dtl_pkg::ACT_BYTE, s[i]);
    endtask

    task automatic await_tokens();
        byte_valid <= 1'b0;
        do
            @(posedge clk);
        while (tokens_due.size() != 0);
    endtask

    task automatic test_directed();
        send_text("@lang[]}");
        send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_TAB);
        send_text("@ b");
        send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_CR);
        send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_LF);
        send_beat(dtl_pkg::ACT_END, 8'h00);
        send_text("{:,");
        send_beat(dtl_pkg::ACT_BYTE, 8'h00);
        send_beat(dtl_pkg::ACT_BYTE, 8'hFF);
        send_beat(dtl_pkg::ACT_END, 8'hFF);
        send_beat(dtl_pkg::ACT_END, 8'h5A);
    endtask

    // sink holds off while bytes keep coming, then the source waits for the backlog
    task automatic test_backpressure();
        src_idle_max = 0;
        sink_hold    = 150;
        repeat (20) send_text("ab,");
        await_tokens();
        src_idle_max = 13;
        send_text("@skip:x");
        send_beat(dtl_pkg::ACT_END, 8'h3C);
    endtask

    task automatic send_piece();
        int    pick;
        int    n;
        string w;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_AT);
            send_text(exact_words[$urandom_range(0, 16)]);
        end
        else if (pick < 32)
        begin
            send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_AT);
            send_text(bracket_heads[$urandom_range(0, 3)]);
            n = $urandom_range(0, 4);
            repeat (n) send_beat(dtl_pkg::ACT_BYTE, word_byte());
            if ($urandom_range(0, 3) != 0)
                send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_RBRACK);
        end
        else if (pick < 38)
        begin
            w = exact_words[$urandom_range(0, 16)];
            case ($urandom_range(0, 3))
                0:
                begin
                    send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_AT);
                    send_beat(dtl_pkg::ACT_BYTE, sep_byte());
                    send_text(w);
                end
                1:
                begin
                    send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_AT);
                    send_text(w.substr(0, w.len() - 2));
                end
                2:
                begin
                    send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_AT);
                    send_text(w);
                    send_beat(dtl_pkg::ACT_BYTE, word_byte());
                end
                default:
                    send_text(w);
            endcase
        end
        else if (pick < 55)
        begin
            n = $urandom_range(1, 12);
            repeat (n) send_beat(dtl_pkg::ACT_BYTE, word_byte());
        end
        else if (pick < 73)
            send_beat(dtl_pkg::ACT_BYTE, punct_bytes[$urandom_range(0, 4)]);
        else if (pick < 86)
            send_beat(dtl_pkg::ACT_BYTE, sep_byte());
        else if (pick < 93)
            send_beat(dtl_pkg::ACT_BYTE, dtl_pkg::CH_LF);
        else if (pick < 99)
            send_beat(dtl_pkg::ACT_BYTE, 8'($urandom_range(0, 255)));
        else
            send_beat(dtl_pkg::ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_streams();
        int goal;
        goal = beats_sent + 1760;
        while (beats_sent < goal)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                src_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 13;
                sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 13;
            end
            send_piece();
        end
        send_beat(dtl_pkg::ACT_END, 8'($urandom_range(0, 255)));
    endtask

    // token sink: random hold before each beat, or a long hold on request
    initial
    begin : token_sink
        int hold;
        token_stall = 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (sink_hold > 0)
            begin
                hold      = sink_hold;
                sink_hold = 0;
            end
            else
                hold = draw_wait(sink_idle_max);
            if (hold > 0)
            begin
                token_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            token_stall <= 1'b0;
            @(posedge clk);
            while (!token_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        dtl_pkg::token_t want;
        if (rst_n && token_valid && !token_stall)
        begin
            if (tokens_due.size() == 0)
            begin
                $error("unexpected token: kind %0d line %0d col %0d len %0d",
                       token_kind, line_number, column_number, token_length);
                mismatches++;
            end
            else
            begin
                want = tokens_due.pop_front();
                if (token_kind !== want.kind)
                begin
                    $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
                    mismatches++;
                end
                if (line_number !== want.line_no)
                begin
                    $error("line_number: expected %0d, got %0d", want.line_no, line_number);
                    mismatches++;
                end
                if (column_number !== want.col_no)
                begin
                    $error("column_number: expected %0d, got %0d", want.col_no,
                           column_number);
                    mismatches++;
                end
                if (token_length !== want.len)
                begin
                    $error("token_length: expected %0d, got %0d", want.len, token_length);
                    mismatches++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        action     = dtl_pkg::ACT_BYTE;
        char_code  = 8'h00;
        lex_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random_streams();

        await_tokens();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
